FILE: sv/bcd_calendar_field_editor_defines.svh
// Assertion macros for the BCD calendar field editor checker.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef BCD_CALENDAR_FIELD_EDITOR_DEFINES_SVH
`define BCD_CALENDAR_FIELD_EDITOR_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define BCDCAL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define BCDCAL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked through reset as well
`define BCDCAL_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/bcdcal_pkg.sv
// Shared types, constants and BCD step functions for the calendar field editor.
// No dependencies.
`timescale 1ns / 1ps

package bcdcal_pkg;

    // Command codes carried in s_tuser
    typedef enum logic [3:0] {
        FUNC_LOAD       = 4'd0,
        FUNC_MIN_UP     = 4'd1,
        FUNC_MIN_DOWN   = 4'd2,
        FUNC_HOUR_UP    = 4'd3,
        FUNC_HOUR_DOWN  = 4'd4,
        FUNC_WDAY_UP    = 4'd5,
        FUNC_WDAY_DOWN  = 4'd6,
        FUNC_DATE_UP    = 4'd7,
        FUNC_DATE_DOWN  = 4'd8,
        FUNC_MONTH_UP   = 4'd9,
        FUNC_MONTH_DOWN = 4'd10,
        FUNC_YEAR_UP    = 4'd11,
        FUNC_YEAR_DOWN  = 4'd12,
        FUNC_CLAMP      = 4'd13
    } func_t;

    // Calendar fields, minute in the lowest bits
    typedef struct packed {
        logic [7:0] year;
        logic [4:0] month;
        logic [5:0] date;
        logic [2:0] weekday;
        logic [5:0] hour;
        logic [6:0] minute;
    } cal_t;

    localparam int CAL_W    = $bits(cal_t);
    localparam int TDATA_W  = ((CAL_W + 7) / 8) * 8;
    localparam int TUSER_W  = 4;
    localparam int PAD_W    = TDATA_W - CAL_W;

    // Range limits in BCD
    localparam logic [7:0] BCD_MIN_TOP   = 8'h59;
    localparam logic [7:0] BCD_HOUR_TOP  = 8'h23;
    localparam logic [7:0] BCD_DATE_TOP  = 8'h31;
    localparam logic [7:0] BCD_MONTH_TOP = 8'h12;
    localparam logic [7:0] BCD_YEAR_TOP  = 8'h99;
    localparam logic [7:0] BCD_FEB_DAYS  = 8'h28;
    localparam logic [7:0] BCD_LEAP_DAYS = 8'h29;
    localparam logic [7:0] BCD_SHORT_DAYS = 8'h30;
    localparam logic [2:0] WDAY_TOP      = 3'd7;

    // One BCD count up; anything past 0x99 wraps to zero
    function automatic logic [7:0] bcd_up(input logic [7:0] v);
        logic [7:0] n;
        n = v + 8'd1;
        if (n > BCD_YEAR_TOP) begin
            n = 8'h00;
        end else if (n[3:0] > 4'd9) begin
            n = n + 8'd6;
        end
        return n;
    endfunction

    // One BCD count down; anything past 0x99, including the borrow from zero, gives 0x99
    function automatic logic [7:0] bcd_down(input logic [7:0] v);
        logic [7:0] n;
        n = v - 8'd1;
        if (n > BCD_YEAR_TOP) begin
            n = BCD_YEAR_TOP;
        end else if (n[3:0] > 4'd9) begin
            n = n - 8'd6;
        end
        return n;
    endfunction

endpackage

FILE: sv/bcdcal_update.sv
// Next-state logic for the calendar fields: load, BCD up/down steps and date clamp.
// Depends on bcdcal_pkg.
`timescale 1ns / 1ps

module bcdcal_update (
    input  bcdcal_pkg::func_t func,
    input  bcdcal_pkg::cal_t  cur,
    input  bcdcal_pkg::cal_t  load,
    output bcdcal_pkg::cal_t  nxt
);
    import bcdcal_pkg::*;

    logic [7:0] min_up, min_dn, hour_up, hour_dn, date_up, date_dn, mon_up, mon_dn;
    logic [7:0] days;
    logic       month_ok;
    logic       leap;
    logic [3:0] yr_tens, yr_ones;

    // Step each field on 8 bits
    assign min_up  = bcd_up({1'b0, cur.minute});
    assign min_dn  = bcd_down({1'b0, cur.minute});
    assign hour_up = bcd_up({2'b00, cur.hour});
    assign hour_dn = bcd_down({2'b00, cur.hour});
    assign date_up = bcd_up({2'b00, cur.date});
    assign date_dn = bcd_down({2'b00, cur.date});
    assign mon_up  = bcd_up({3'b000, cur.month});
    assign mon_dn  = bcd_down({3'b000, cur.month});

    // Leap test on the decimal year: (10*tens + ones) mod 4 == (2*tens + ones) mod 4
    assign yr_tens = cur.year[7:4];
    assign yr_ones = cur.year[3:0];
    assign leap    = !yr_ones[0] && (yr_ones[1] == yr_tens[0]);

    // Month length; months outside 01-09 and 10-12 leave the date alone
    always_comb begin
        month_ok = ((cur.month >= 5'h01) && (cur.month <= 5'h09)) ||
                   ((cur.month >= 5'h10) && (cur.month <= 5'h12));
        if (cur.month == 5'h02) begin
            days = leap ? BCD_LEAP_DAYS : BCD_FEB_DAYS;
        end else if ((cur.month == 5'h04) || (cur.month == 5'h06) ||
                     (cur.month == 5'h09) || (cur.month == 5'h11)) begin
            days = BCD_SHORT_DAYS;
        end else begin
            days = BCD_DATE_TOP;
        end
    end

    // Apply the command
    always_comb begin
        nxt = cur;
        unique case (func)
            FUNC_LOAD: begin
                nxt = load;
            end
            FUNC_MIN_UP: begin
                nxt.minute = (cur.minute == BCD_MIN_TOP[6:0]) ? 7'h00 : min_up[6:0];
            end
            FUNC_MIN_DOWN: begin
                nxt.minute = (cur.minute == 7'h00) ? BCD_MIN_TOP[6:0] : min_dn[6:0];
            end
            FUNC_HOUR_UP: begin
                nxt.hour = (cur.hour == BCD_HOUR_TOP[5:0]) ? 6'h00 : hour_up[5:0];
            end
            FUNC_HOUR_DOWN: begin
                nxt.hour = (cur.hour == 6'h00) ? BCD_HOUR_TOP[5:0] : hour_dn[5:0];
            end
            FUNC_WDAY_UP: begin
                nxt.weekday = (cur.weekday == WDAY_TOP) ? 3'd1 : cur.weekday + 3'd1;
            end
            FUNC_WDAY_DOWN: begin
                nxt.weekday = (cur.weekday == 3'd1) ? WDAY_TOP : cur.weekday - 3'd1;
            end
            FUNC_DATE_UP: begin
                nxt.date = (cur.date == BCD_DATE_TOP[5:0]) ? 6'h01 : date_up[5:0];
            end
            FUNC_DATE_DOWN: begin
                nxt.date = (cur.date == 6'h01) ? BCD_DATE_TOP[5:0] : date_dn[5:0];
            end
            FUNC_MONTH_UP: begin
                nxt.month = (cur.month == BCD_MONTH_TOP[4:0]) ? 5'h01 : mon_up[4:0];
            end
            FUNC_MONTH_DOWN: begin
                nxt.month = (cur.month == 5'h01) ? BCD_MONTH_TOP[4:0] : mon_dn[4:0];
            end
            FUNC_YEAR_UP: begin
                nxt.year = bcd_up(cur.year);
            end
            FUNC_YEAR_DOWN: begin
                nxt.year = bcd_down(cur.year);
            end
            FUNC_CLAMP: begin
                if (month_ok && ({2'b00, cur.date} > days)) begin
                    nxt.date = days[5:0];
                end
            end
            default: begin
                nxt = cur;
            end
        endcase
    end

endmodule

FILE: sv/bcd_calendar_field_editor.sv
// Top level of the BCD calendar field editor: input register, calendar state, result register.
// Depends on bcdcal_pkg and bcdcal_update.
//
//  channel | dir | tdata                          | tuser
//  s_      | in  | load_minute..load_year, 35 b   | func, 4 b
//  m_      | out | minute..year, 35 b             | none
//
// Items are accepted one per cycle while the result channel does not stall; each accepted item
// passes from the input register to the result register, where its result is taken on an edge
// with m_tready high. The command is applied combinationally between the input register and the
// result register, where the calendar state is updated as well.
// aresetn is synchronous: it empties both registers and sets the calendar to 00:00,
// weekday 1, date 01, month 01, year 00. A stalled result holds, the input register takes
// one more item behind it, and s_tready drops until the result is taken.
`timescale 1ns / 1ps

module bcd_calendar_field_editor (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // load_minute[6:0], load_hour[12:7], load_weekday[15:13], load_date[21:16],
    // load_month[26:22], load_year[34:27], zero pad above
    input  logic [bcdcal_pkg::TDATA_W-1:0] s_tdata,
    // func[3:0]
    input  logic [bcdcal_pkg::TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // minute[6:0], hour[12:7], weekday[15:13], date[21:16], month[26:22], year[34:27],
    // zero pad above
    output logic [bcdcal_pkg::TDATA_W-1:0] m_tdata
);
    import bcdcal_pkg::*;

    localparam cal_t CAL_RESET = '{year: 8'h00, month: 5'h01, date: 6'h01,
                                   weekday: 3'd1, hour: 6'h00, minute: 7'h00};

    logic  in_valid_reg;
    func_t func_reg;
    cal_t  load_reg;
    cal_t  cal_reg, cal_next;
    logic  out_valid_reg;
    cal_t  out_reg;
    logic  advance;

    // Move the held item into the result register when that register is free or drains
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    bcdcal_update u_update (
        .func (func_reg),
        .cur  (cal_reg),
        .load (load_reg),
        .nxt  (cal_next)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            func_reg <= func_t'(s_tuser);
            load_reg <= s_tdata[CAL_W-1:0];
        end
    end

    // Calendar state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg       <= CAL_RESET;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            cal_reg       <= cal_next;
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_reg <= cal_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_reg};

endmodule

FILE: sv/bcdcal_checker.sv
// Port-level checker for the BCD calendar field editor, bound to the top level.
// Depends on bcdcal_pkg and bcd_calendar_field_editor_defines.svh.
`timescale 1ns / 1ps
`include "bcd_calendar_field_editor_defines.svh"

module bcdcal_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [bcdcal_pkg::TDATA_W-1:0] s_tdata,
    input logic [bcdcal_pkg::TUSER_W-1:0] s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bcdcal_pkg::TDATA_W-1:0] m_tdata
);
    import bcdcal_pkg::*;

    logic in_item;
    assign in_item = s_tvalid && s_tready && (s_tuser == s_tuser) && (s_tdata == s_tdata);

    // Hold a stalled result
    `BCDCAL_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
    // Empty the result side out of reset
    `BCDCAL_ASSERT_RST(a_reset_empty, !aresetn, !m_tvalid, "result valid after reset")
    // Check that a valid result follows each accepted item
    `BCDCAL_ASSERT_NXT(a_item_result, in_item, ##1 m_tvalid, "accepted item produced no result")
    // Keep the padding above the fields at zero
    `BCDCAL_ASSERT_IMP(a_pad_zero, m_tvalid, m_tdata[TDATA_W-1:CAL_W] == '0, "result padding not zero")

endmodule

bind bcd_calendar_field_editor bcdcal_checker u_bcdcal_checker (.*);

FILE: tb/tb_top.sv
// Self-checking bench for the BCD calendar field editor: directed wrap and clamp corners,
// then random command streams with bursty input and a stalling result channel.
// Depends on bcdcal_pkg and bcd_calendar_field_editor.
`timescale 1ns / 1ps

module tb_top;
    import bcdcal_pkg::*;

    // Command codes the block leaves unused
    localparam logic [3:0] FUNC_SPARE_A = 4'd14;
    localparam logic [3:0] FUNC_SPARE_B = 4'd15;

    localparam int RANDOM_CMDS      = 1500;
    localparam int LONG_HOLD_AT     = 700;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_LIMIT      = 20000;
    localparam int SETTLE_CYCLES    = 8;

    typedef enum {READY_ALWAYS, READY_HALF, READY_MOSTLY, READY_RARELY} ready_mode_t;

    // Tracks the calendar the block should hold and the results still owed
    class calendar_tracker;
        cal_t now_fields;
        cal_t owed_fields[$];
        int   errors;
        int   results;
        int   loads;
        int   clamps;
        int   clamp_cuts;
        int   spares;

        function new();
            now_fields.minute  = 7'h00;
            now_fields.hour    = 6'h00;
            now_fields.weekday = 3'd1;
            now_fields.date    = 6'h01;
            now_fields.month   = 5'h01;
            now_fields.year    = 8'h00;
            errors     = 0;
            results    = 0;
            loads      = 0;
            clamps     = 0;
            clamp_cuts = 0;
            spares     = 0;
        endfunction

        // One BCD count up or down on a byte; past 0x99 lands on the far end
        function logic [7:0] bcd_step(input logic [7:0] v, input bit up);
            logic [7:0] n;
            n = up ? v + 8'd1 : v - 8'd1;
            if (n > BCD_YEAR_TOP) begin
                return up ? 8'h00 : BCD_YEAR_TOP;
            end
            if (n[3:0] > 4'd9) begin
                n = up ? n + 8'd6 : n - 8'd6;
            end
            return n;
        endfunction

        // Days in the month as BCD, zero for a month code that is not a month
        function logic [7:0] month_length(input logic [4:0] m, input logic [7:0] y);
            int dec_year;
            dec_year = int'(y[7:4]) * 10 + int'(y[3:0]);
            case (m)
                5'h02: begin
                    return (dec_year % 4 == 0) ? BCD_LEAP_DAYS : BCD_FEB_DAYS;
                end
                5'h04, 5'h06, 5'h09, 5'h11: begin
                    return BCD_SHORT_DAYS;
                end
                5'h01, 5'h03, 5'h05, 5'h07, 5'h08, 5'h10, 5'h12: begin
                    return BCD_DATE_TOP;
                end
                default: begin
                    return 8'h00;
                end
            endcase
        endfunction

        // Apply one command to the tracked calendar
        function void apply_command(input logic [3:0] func, input cal_t load);
            logic [7:0] t;
            logic [7:0] days;
            case (func)
                FUNC_LOAD: begin
                    now_fields = load;
                    loads++;
                end
                FUNC_MIN_UP: begin
                    t = bcd_step({1'b0, now_fields.minute}, 1'b1);
                    now_fields.minute = (now_fields.minute == BCD_MIN_TOP[6:0]) ? 7'h00
                                      : t[6:0];
                end
                FUNC_MIN_DOWN: begin
                    t = bcd_step({1'b0, now_fields.minute}, 1'b0);
                    now_fields.minute = (now_fields.minute == 7'h00) ? BCD_MIN_TOP[6:0] : t[6:0];
                end
                FUNC_HOUR_UP: begin
                    t = bcd_step({2'b0, now_fields.hour}, 1'b1);
                    now_fields.hour = (now_fields.hour == BCD_HOUR_TOP[5:0]) ? 6'h00 : t[5:0];
                end
                FUNC_HOUR_DOWN: begin
                    t = bcd_step({2'b0, now_fields.hour}, 1'b0);
                    now_fields.hour = (now_fields.hour == 6'h00) ? BCD_HOUR_TOP[5:0] : t[5:0];
                end
                FUNC_WDAY_UP: begin
                    now_fields.weekday = (now_fields.weekday == WDAY_TOP) ? 3'd1
                                       : now_fields.weekday + 3'd1;
                end
                FUNC_WDAY_DOWN: begin
                    now_fields.weekday = (now_fields.weekday == 3'd1) ? WDAY_TOP
                                       : now_fields.weekday - 3'd1;
                end
                FUNC_DATE_UP: begin
                    t = bcd_step({2'b0, now_fields.date}, 1'b1);
                    now_fields.date = (now_fields.date == BCD_DATE_TOP[5:0]) ? 6'h01 : t[5:0];
                end
                FUNC_DATE_DOWN: begin
                    t = bcd_step({2'b0, now_fields.date}, 1'b0);
                    now_fields.date = (now_fields.date == 6'h01) ? BCD_DATE_TOP[5:0] : t[5:0];
                end
                FUNC_MONTH_UP: begin
                    t = bcd_step({3'b0, now_fields.month}, 1'b1);
                    now_fields.month = (now_fields.month == BCD_MONTH_TOP[4:0]) ? 5'h01
                                     : t[4:0];
                end
                FUNC_MONTH_DOWN: begin
                    t = bcd_step({3'b0, now_fields.month}, 1'b0);
                    now_fields.month = (now_fields.month == 5'h01) ? BCD_MONTH_TOP[4:0]
                                     : t[4:0];
                end
                FUNC_YEAR_UP: begin
                    now_fields.year = bcd_step(now_fields.year, 1'b1);
                end
                FUNC_YEAR_DOWN: begin
                    now_fields.year = bcd_step(now_fields.year, 1'b0);
                end
                FUNC_CLAMP: begin
                    clamps++;
                    days = month_length(now_fields.month, now_fields.year);
                    if (days != 8'h00 && {2'b0, now_fields.date} > days) begin
                        now_fields.date = days[5:0];
                        clamp_cuts++;
                    end
                end
                default: begin
                    spares++;
                end
            endcase
        endfunction

        // Record an accepted command and queue the calendar it leaves behind
        function void note_command(input logic [3:0] func, input logic [TDATA_W-1:0] data);
            apply_command(func, cal_t'(data[CAL_W-1:0]));
            owed_fields.push_back(now_fields);
        endfunction

        function void compare(input string field, input logic [7:0] want,
                              input logic [7:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                errors++;
            end
        endfunction

        // Check one result against the oldest owed calendar
        function void check_fields(input logic [TDATA_W-1:0] data);
            cal_t got;
            cal_t want;
            got = data[CAL_W-1:0];
            results++;
            if (owed_fields.size() == 0) begin
                $error("result 0x%0h arrived with no command outstanding", data);
                errors++;
                return;
            end
            want = owed_fields.pop_front();
            compare("minute",  8'(want.minute),  8'(got.minute));
            compare("hour",    8'(want.hour),    8'(got.hour));
            compare("weekday", 8'(want.weekday), 8'(got.weekday));
            compare("date",    8'(want.date),    8'(got.date));
            compare("month",   8'(want.month),   8'(got.month));
            compare("year",    want.year,        got.year);
            compare("pad",     8'h00,            8'(data[TDATA_W-1:CAL_W]));
        endfunction

        function int pending();
            return owed_fields.size();
        endfunction
    endclass

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata  = '0;
    logic [TUSER_W-1:0] s_tuser  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;

    calendar_tracker tracker = new();
    int cmds_accepted    = 0;
    int in_stall         = 0;
    int longest_in_stall = 0;

    bcd_calendar_field_editor u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Watch both channels: predict on each accepted item, check each taken result
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                tracker.note_command(s_tuser, s_tdata);
                cmds_accepted <= cmds_accepted + 1;
            end
            if (m_tvalid && m_tready) begin
                tracker.check_fields(m_tdata);
            end
            if (s_tvalid && !s_tready) begin
                in_stall <= in_stall + 1;
                if (in_stall + 1 > longest_in_stall) begin
                    longest_in_stall <= in_stall + 1;
                end
            end else begin
                in_stall <= 0;
            end
        end
    end

    // Result side: switch stall patterns now and then, and hold off once for a long stretch
    initial begin
        ready_mode_t mode;
        int          mode_left;
        int          hold_left;
        bit          hold_done;
        mode      = READY_ALWAYS;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (!hold_done && cmds_accepted >= LONG_HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = ready_mode_t'($urandom_range(3));
                mode_left = $urandom_range(256, 32);
            end
            mode_left--;
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    READY_ALWAYS: m_tready <= 1'b1;
                    READY_HALF:   m_tready <= 1'($urandom_range(1));
                    READY_MOSTLY: m_tready <= ($urandom_range(7) != 0);
                    default:      m_tready <= ($urandom_range(3) == 0);
                endcase
            end
        end
    end

    // Offer one item and hold it until the block takes it
    task automatic send_cmd(input logic [3:0] func, input cal_t fields);
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {{PAD_W{1'b0}}, fields};
        do begin
            @(posedge aclk);
        end while (!s_tready);
    endtask

    // Drop valid and wait out the requested gap
    task automatic idle_sender(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    function automatic cal_t pack_fields(input logic [6:0] mi, input logic [5:0] hr,
                                         input logic [2:0] wd, input logic [5:0] dt,
                                         input logic [4:0] mo, input logic [7:0] yr);
        cal_t c;
        c.minute  = mi;
        c.hour    = hr;
        c.weekday = wd;
        c.date    = dt;
        c.month   = mo;
        c.year    = yr;
        return c;
    endfunction

    // Decimal value in lo..hi as BCD, ends of the range picked often
    function automatic logic [7:0] bcd_pick(input int lo, input int hi);
        int         d;
        logic [7:0] r;
        case ($urandom_range(3))
            0:       d = lo;
            1:       d = hi;
            default: d = $urandom_range(hi, lo);
        endcase
        r[7:4] = 4'(d / 10);
        r[3:0] = 4'(d % 10);
        return r;
    endfunction

    // Load content: mostly a valid calendar, sometimes raw bits of every field
    function automatic cal_t random_load();
        logic [63:0] raw;
        cal_t        c;
        if ($urandom_range(3) == 0) begin
            raw = {$urandom, $urandom};
            c   = raw[CAL_W-1:0];
        end else begin
            c.minute  = 7'(bcd_pick(0, 59));
            c.hour    = 6'(bcd_pick(0, 23));
            c.weekday = 3'($urandom_range(7, 1));
            c.date    = 6'(bcd_pick(1, 31));
            c.month   = 5'(bcd_pick(1, 12));
            c.year    = bcd_pick(0, 99);
        end
        return c;
    endfunction

    // Stimulus
    initial begin
        int         burst_left;
        int         k;
        int         pick;
        logic [3:0] f;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Every field at its top, then each step across its wrap point
        send_cmd(FUNC_LOAD, pack_fields(7'h59, 6'h23, 3'd7, 6'h31, 5'h12, 8'h99));
        send_cmd(FUNC_MIN_UP, '1);
        send_cmd(FUNC_MIN_DOWN, '1);
        send_cmd(FUNC_HOUR_UP, '1);
        send_cmd(FUNC_HOUR_DOWN, '1);
        send_cmd(FUNC_WDAY_UP, '1);
        send_cmd(FUNC_WDAY_DOWN, '1);
        send_cmd(FUNC_DATE_UP, '1);
        send_cmd(FUNC_DATE_DOWN, '1);
        send_cmd(FUNC_MONTH_UP, '1);
        send_cmd(FUNC_MONTH_DOWN, '1);
        send_cmd(FUNC_YEAR_UP, '1);
        send_cmd(FUNC_YEAR_DOWN, '1);

        // All-ones load: out-of-range fields, clamp on a month that is not a month
        send_cmd(FUNC_LOAD, '1);
        send_cmd(FUNC_CLAMP, '0);
        send_cmd(FUNC_MIN_UP, '0);
        send_cmd(FUNC_YEAR_UP, '0);

        // February in a leap year and the year after, weekday zero stepped down
        send_cmd(FUNC_LOAD, pack_fields(7'h00, 6'h00, 3'd0, 6'h31, 5'h02, 8'h24));
        send_cmd(FUNC_WDAY_DOWN, '0);
        send_cmd(FUNC_CLAMP, '0);
        send_cmd(FUNC_YEAR_UP, '0);
        send_cmd(FUNC_DATE_UP, '0);
        send_cmd(FUNC_CLAMP, '0);

        // Thirty-day month, weekday zero stepped up, then the unused codes
        send_cmd(FUNC_LOAD, pack_fields(7'h00, 6'h00, 3'd0, 6'h31, 5'h04, 8'h00));
        send_cmd(FUNC_WDAY_UP, '0);
        send_cmd(FUNC_CLAMP, '0);
        send_cmd(FUNC_SPARE_A, '1);
        send_cmd(FUNC_SPARE_B, '1);

        // Random commands in bursts; non-load items carry junk load fields
        burst_left = 0;
        for (k = 0; k < RANDOM_CMDS; k++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(40, 1);
                if ($urandom_range(2) != 0) begin
                    idle_sender($urandom_range(6, 1));
                end
            end
            burst_left--;
            pick = $urandom_range(99);
            if (pick < 12) begin
                f = FUNC_LOAD;
            end else if (pick < 14) begin
                f = $urandom_range(1) ? FUNC_SPARE_A : FUNC_SPARE_B;
            end else if (pick < 30) begin
                f = FUNC_CLAMP;
            end else begin
                f = 4'($urandom_range(FUNC_YEAR_DOWN, FUNC_MIN_UP));
            end
            send_cmd(f, random_load());
        end
        s_tvalid <= 1'b0;

        // Drain: let the monitor see the last item, then wait for owed results
        @(posedge aclk);
        k = 0;
        while (tracker.pending() != 0 && k < DRAIN_LIMIT) begin
            @(posedge aclk);
            k++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (tracker.pending() != 0) begin
            $error("%0d results never arrived", tracker.pending());
            tracker.errors++;
        end

        $display("Covered %0d commands: %0d loads, %0d clamps (%0d cut the date), %0d unused",
                 cmds_accepted, tracker.loads, tracker.clamps, tracker.clamp_cuts,
                 tracker.spares);
        $display("Checked %0d results; longest input back-pressure %0d cycles",
                 tracker.results, longest_in_stall);
        if (tracker.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
